[hw/rtl/tia_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tia_pkg
// Shared types and constants of the tagged 63-bit integer ALU.
// ---------------------------------------------------------------------------
package tia_pkg;

    localparam int WordW   = 64;
    localparam int MagW    = WordW - 1;   // magnitude of a decoded value
    localparam int NumCells = MagW;       // one quotient bit per cell
    localparam int PrepStages = 5;

    localparam logic [4:0] CMD_ZERO   = 5'd0;
    localparam logic [4:0] CMD_ONE    = 5'd1;
    localparam logic [4:0] CMD_NEG    = 5'd2;
    localparam logic [4:0] CMD_ABS    = 5'd3;
    localparam logic [4:0] CMD_ADD    = 5'd4;
    localparam logic [4:0] CMD_SUB    = 5'd5;
    localparam logic [4:0] CMD_MUL    = 5'd6;
    localparam logic [4:0] CMD_DIV    = 5'd7;
    localparam logic [4:0] CMD_REM    = 5'd8;
    localparam logic [4:0] CMD_SHL    = 5'd9;
    localparam logic [4:0] CMD_SHR    = 5'd10;
    localparam logic [4:0] CMD_OR     = 5'd11;
    localparam logic [4:0] CMD_AND    = 5'd12;
    localparam logic [4:0] CMD_XOR    = 5'd13;
    localparam logic [4:0] CMD_NOT    = 5'd14;
    localparam logic [4:0] CMD_ENCODE = 5'd15;
    localparam logic [4:0] CMD_DECODE = 5'd16;

    localparam logic [WordW-1:0] TaggedZero = 64'd1;
    localparam logic [WordW-1:0] TaggedOne  = 64'd3;

    typedef struct packed {
        logic [WordW-1:0] res;
        logic             err;
        logic             is_mul;
        logic             is_div;
        logic             is_rem;
        logic [WordW-1:0] ma;
        logic [WordW-1:0] mb;
        logic [WordW-1:0] p_ll;
        logic [31:0]      p_x;
        logic [MagW-1:0]  rem_r;
        logic [MagW-1:0]  quo;
        logic [MagW-1:0]  dvs;
        logic             neg_q;
        logic             neg_r;
    } t_word;

endpackage

[hw/rtl/tia_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tia_req_if / tia_rsp_if
// Valid/ready channels for ALU requests and results.
// ---------------------------------------------------------------------------
interface tia_req_if;
    logic              valid;
    logic              ready;
    logic [4:0]        command;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;

    modport source (output valid, command, operand_a, operand_b, input ready);
    modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface tia_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [63:0] result;
    logic              error;

    modport source (output valid, result, error, input ready);
    modport sink   (input valid, result, error, output ready);
endinterface

[hw/rtl/tia_prep.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tia_prep
// Decode, simple ops, shifts, divider setup and a split 64-bit multiply.
// ---------------------------------------------------------------------------
module tia_prep
    import tia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_cmd,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_valid,
    input  logic        i_ready,
    output t_word       o_word
);

    logic  r_v [PrepStages];
    t_word r_w [PrepStages];
    t_word n_w [PrepStages];
    logic  rdy [PrepStages+1];

    always_comb begin
        rdy[PrepStages] = i_ready;
        for (int k = PrepStages - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    // stage 0: decode and everything that needs no multiply or divide
    always_comb begin
        logic [63:0] da;
        logic [63:0] db;
        logic [63:0] na;
        logic [63:0] nb;
        logic [63:0] sh;
        logic        bad_sh;
        da = {i_a[63], i_a[63:1]};
        db = {i_b[63], i_b[63:1]};
        na = 64'd0 - da;
        nb = 64'd0 - db;
        bad_sh = db[63] || (db[62:6] != '0);
        sh = 64'd0;
        n_w[0]        = '0;
        n_w[0].res    = TaggedZero;
        n_w[0].ma     = da;
        n_w[0].mb     = db;
        n_w[0].quo    = da[63] ? na[MagW-1:0] : da[MagW-1:0];
        n_w[0].dvs    = db[63] ? nb[MagW-1:0] : db[MagW-1:0];
        n_w[0].neg_q  = da[63] ^ db[63];
        n_w[0].neg_r  = da[63];
        case (i_cmd)
            CMD_ZERO:   n_w[0].res = TaggedZero;
            CMD_ONE:    n_w[0].res = TaggedOne;
            CMD_NEG:    n_w[0].res = 64'd2 - i_a;
            CMD_ABS:    n_w[0].res = i_a[63] ? 64'd2 - i_a : i_a;
            CMD_ADD:    n_w[0].res = i_a + i_b - 64'd1;
            CMD_SUB:    n_w[0].res = i_a - i_b + 64'd1;
            CMD_MUL:    n_w[0].is_mul = 1'b1;
            CMD_DIV, CMD_REM: begin
                if (db == 64'd0) begin
                    n_w[0].err = 1'b1;
                end else begin
                    n_w[0].is_div = (i_cmd == CMD_DIV);
                    n_w[0].is_rem = (i_cmd == CMD_REM);
                end
            end
            CMD_SHL, CMD_SHR: begin
                if (bad_sh) begin
                    n_w[0].err = 1'b1;
                end else begin
                    // keep the right shift in its own signed expression
                    if (i_cmd == CMD_SHL) begin
                        sh = da << db[5:0];
                    end else begin
                        sh = $signed(da) >>> db[5:0];
                    end
                    n_w[0].res = {sh[62:0], 1'b1};
                end
            end
            CMD_OR:     n_w[0].res = i_a | i_b;
            CMD_AND:    n_w[0].res = i_a & i_b;
            CMD_XOR:    n_w[0].res = (i_a ^ i_b) | 64'd1;
            CMD_NOT:    n_w[0].res = ~i_a | 64'd1;
            CMD_ENCODE: n_w[0].res = {i_a[62:0], 1'b1};
            CMD_DECODE: n_w[0].res = da;
            default:    n_w[0].err = 1'b1;
        endcase
    end

    // stages 1..4: partial products, one multiplier each in stages 1..3; stage 4 sums them
    always_comb begin
        n_w[1] = r_w[0];
        n_w[1].p_ll = {32'd0, r_w[0].ma[31:0]} * {32'd0, r_w[0].mb[31:0]};
        n_w[2] = r_w[1];
        n_w[2].p_x = r_w[1].ma[31:0] * r_w[1].mb[63:32];
        n_w[3] = r_w[2];
        n_w[3].p_x = r_w[2].p_x + r_w[2].ma[63:32] * r_w[2].mb[31:0];
        n_w[4] = r_w[3];
        if (r_w[3].is_mul) begin
            n_w[4].res = {r_w[3].p_ll[62:0] + {r_w[3].p_x[30:0], 32'd0}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PrepStages; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= (k == 0) ? i_valid : r_v[(k > 0) ? k - 1 : 0];
            end
            if (rdy[k]) begin
                r_w[k] <= n_w[k];
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[PrepStages-1];
    assign o_word  = r_w[PrepStages-1];

endmodule

[hw/rtl/tia_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tia_cell
// One restoring division step: shift in a dividend bit, trial subtract.
// ---------------------------------------------------------------------------
module tia_cell
    import tia_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_word i_word,
    output logic  o_valid,
    input  logic  i_ready,
    output t_word o_word
);

    logic        r_v;
    t_word       r_w;
    t_word       n_w;
    logic [MagW:0] trial;
    logic [MagW:0] diff;
    logic        ge;

    assign trial = {i_word.rem_r, i_word.quo[MagW-1]};
    assign diff  = trial - {1'b0, i_word.dvs};
    assign ge    = trial >= {1'b0, i_word.dvs};

    always_comb begin
        n_w       = i_word;
        n_w.rem_r = ge ? diff[MagW-1:0] : trial[MagW-1:0];
        n_w.quo   = {i_word.quo[MagW-2:0], ge};
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready) begin
            r_w <= n_w;
        end
    end

    assign o_valid = r_v;
    assign o_word  = r_w;

endmodule

[hw/rtl/tia_post.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tia_post
// Apply signs to quotient or remainder, tag it, hold the result word.
// ---------------------------------------------------------------------------
module tia_post
    import tia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_word       i_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result,
    output logic        o_error
);

    logic        r_v;
    logic [63:0] r_res;
    logic        r_err;
    logic [63:0] n_res;
    logic [63:0] q_val;
    logic [63:0] m_val;

    always_comb begin
        q_val = i_word.neg_q ? 64'd0 - {1'b0, i_word.quo} : {1'b0, i_word.quo};
        m_val = i_word.neg_r ? 64'd0 - {1'b0, i_word.rem_r} : {1'b0, i_word.rem_r};
        n_res = i_word.res;
        if (i_word.is_div) begin
            n_res = {q_val[62:0], 1'b1};
        end else if (i_word.is_rem) begin
            n_res = {m_val[62:0], 1'b1};
        end
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready) begin
            r_res <= n_res;
            r_err <= i_word.err;
        end
    end

    assign o_valid  = r_v;
    assign o_result = r_res;
    assign o_error  = r_err;

endmodule

[hw/rtl/tagged_int63_alu.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tagged_int63_alu
// Pipeline: 5 prep stages, 63 divider cells and 1 output stage, the same path
// for every command; the divider chain of one quotient bit per cell sets its length.
// Throughput: one word per cycle unless the output stalls; every stage has
// its own valid and fills bubbles while the output is stalled.
// Reset: synchronous, active low, clears all stage valids.
// ---------------------------------------------------------------------------
module tagged_int63_alu
    import tia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tia_req_if.sink   i_req,
    tia_rsp_if.source o_rsp
);

    logic  c_v   [NumCells+1];
    logic  c_rdy [NumCells+1];
    t_word c_w   [NumCells+1];

    tia_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_cmd   (i_req.command),
        .i_a     (64'(unsigned'(i_req.operand_a))),
        .i_b     (64'(unsigned'(i_req.operand_b))),
        .o_valid (c_v[0]),
        .i_ready (c_rdy[0]),
        .o_word  (c_w[0])
    );

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        tia_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_v[g]),
            .o_ready (c_rdy[g]),
            .i_word  (c_w[g]),
            .o_valid (c_v[g+1]),
            .i_ready (c_rdy[g+1]),
            .o_word  (c_w[g+1])
        );
    end

    logic [63:0] res;

    tia_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_v[NumCells]),
        .o_ready  (c_rdy[NumCells]),
        .i_word   (c_w[NumCells]),
        .o_valid  (o_rsp.valid),
        .i_ready  (o_rsp.ready),
        .o_result (res),
        .o_error  (o_rsp.error)
    );

    assign o_rsp.result = signed'(res);

    // an error word always carries tagged zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.error |-> res == TaggedZero)
        else $error("error word without tagged zero");

    // an empty output stage means every stage can take a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.valid |-> i_req.ready)
        else $error("input stalled with empty output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("output valid after reset");

endmodule

[sim/tagged_int63_alu_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tagged_int63_alu_checker
// Watches the request and result channels of the tagged 63-bit ALU, works
// out the expected result of every accepted request and compares each
// accepted result word against the oldest one still outstanding.
// ---------------------------------------------------------------------------
module tagged_int63_alu_checker
    import tia_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tia_req_if.sink    i_req,
    tia_rsp_if.sink    i_rsp,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [63:0] word;
        logic        err;
    } t_alu_result;

    t_alu_result pending_results[$];

    function automatic logic [63:0] tag(input logic [63:0] v);
        return {v[62:0], 1'b1};
    endfunction

    function automatic logic [63:0] untag(input logic [63:0] x);
        return {x[63], x[63:1]};
    endfunction

    function automatic t_alu_result compute_alu(input logic [4:0] cmd,
                                                input logic [63:0] a,
                                                input logic [63:0] b);
        t_alu_result r;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        sa = untag(a);
        sb = untag(b);
        r.word = TaggedZero;
        r.err = 1'b0;
        case (cmd)
            CMD_ZERO:   r.word = TaggedZero;
            CMD_ONE:    r.word = TaggedOne;
            CMD_NEG:    r.word = 64'd2 - a;
            CMD_ABS:    r.word = a[63] ? 64'd2 - a : a;
            CMD_ADD:    r.word = a + b - 64'd1;
            CMD_SUB:    r.word = a - b + 64'd1;
            CMD_MUL:    r.word = tag(sa * sb);
            CMD_DIV, CMD_REM: begin
                if (sb == 0) begin
                    r.err = 1'b1;
                end else begin
                    r.word = tag(cmd == CMD_DIV ? sa / sb : sa % sb);
                end
            end
            CMD_SHL, CMD_SHR: begin
                if (sb < 0 || sb > 63) begin
                    r.err = 1'b1;
                end else if (cmd == CMD_SHL) begin
                    r.word = tag(sa <<< sb[5:0]);
                end else begin
                    r.word = tag(sa >>> sb[5:0]);
                end
            end
            CMD_OR:     r.word = a | b;
            CMD_AND:    r.word = a & b;
            CMD_XOR:    r.word = (a ^ b) | 64'd1;
            CMD_NOT:    r.word = ~a | 64'd1;
            CMD_ENCODE: r.word = tag(a);
            CMD_DECODE: r.word = sa;
            default:    r.err = 1'b1;
        endcase
        return r;
    endfunction

    assign o_pending = pending_results.size();

    always @(posedge i_clk) begin
        t_alu_result want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_req.valid && i_req.ready)
                pending_results.push_back(compute_alu(i_req.command, i_req.operand_a,
                                                      i_req.operand_b));
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result word %h err %b", $realtime,
                             i_rsp.result, i_rsp.error);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (i_rsp.result !== want.word || i_rsp.error !== want.err) begin
                        $display("%0t: mismatch expected %h err %b, actual %h err %b",
                                 $realtime, want.word, want.err, i_rsp.result, i_rsp.error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/tagged_int63_alu_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tagged_int63_alu_test
// Drives directed and random ALU requests with random gaps and result
// stalls, including a long result hold-off, and reports the verdict.
// ---------------------------------------------------------------------------
module tagged_int63_alu_test;
    import tia_pkg::*;

    localparam int RandomWords = 660;
    localparam int Latency     = 69;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    bit   long_hold = 1'b0;

    tia_req_if req_bus();
    tia_rsp_if rsp_bus();

    tagged_int63_alu dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus.sink),
        .o_rsp  (rsp_bus.source)
    );

    tagged_int63_alu_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus.sink),
        .i_rsp       (rsp_bus.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        req_bus.valid = 1'b0;
        req_bus.command = CMD_ZERO;
        req_bus.operand_a = '0;
        req_bus.operand_b = '0;
        rsp_bus.ready = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // small tagged value, often in the shift-count range
    function automatic logic [63:0] tag_small(input int v);
        logic [63:0] w;
        w = 64'(signed'(v));
        return {w[62:0], 1'b1};
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return tag_small($urandom_range(0, 70) - 3);
            1:       return tag_small(0);
            2:       return {1'b1, 62'd0, 1'b1};
            3:       return {1'b0, {62{1'b1}}, 1'b1};
            4:       return rand64();
            default: return {rand64() >> $urandom_range(0, 63)} | 64'd1;
        endcase
    endfunction

    // Unless quick, drop valid for a random gap, then hold the word until it is taken.
    // Valid stays high after the accept so back-to-back words need no gap.
    task automatic send_word(input logic [4:0] cmd, input logic [63:0] a,
                             input logic [63:0] b, input bit quick);
        int gap;
        gap = quick ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.command <= cmd;
        req_bus.operand_a <= a;
        req_bus.operand_b <= b;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                rsp_bus.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall == 0) begin
                rsp_bus.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                rsp_bus.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [4:0] cmd;
        bit burst;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command, zero divisor, bad shift counts, bad commands
        for (int c = 0; c <= 16; c++)
            send_word(5'(c), {1'b1, 63'd1}, tag_small(-1), 0);
        send_word(CMD_DIV, rand64(), tag_small(0), 0);
        send_word(CMD_REM, rand64(), 64'd0, 0);
        send_word(CMD_SHL, tag_small(5), tag_small(64), 0);
        send_word(CMD_SHR, {1'b1, 63'd1}, tag_small(63), 0);
        send_word(CMD_DIV, {1'b1, 63'd1}, tag_small(-1), 0);
        send_word(CMD_ENCODE, {64{1'b1}}, '0, 0);
        send_word(5'd31, {64{1'b1}}, {64{1'b1}}, 0);
        send_word(5'd17, '0, '0, 0);
        req_bus.valid <= 1'b0;

        // pause until every result is back
        @(posedge i_clk iff pending == 0);

        // back-to-back words against a long result hold-off
        long_hold = 1'b1;
        for (int i = 0; i < 120; i++)
            send_word(5'($urandom_range(0, 16)), rand_operand(), rand_operand(), 1);

        for (int i = 0; i < RandomWords; i++) begin
            cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                               : 5'($urandom_range(0, 16));
            burst = (i % 100) < 30;
            send_word(cmd, rand_operand(), rand_operand(), burst);
        end
        req_bus.valid <= 1'b0;

        @(posedge i_clk iff pending == 0);
        repeat (Latency + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS tagged_int63_alu");
        else
            $display("FAIL tagged_int63_alu");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL tagged_int63_alu");
        $finish;
    end

endmodule
